// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; sgt_datapath includes them.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define SGT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define SGT_ASSERT(lbl, prop, msg)

`define SGT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: hw/rtl/sgt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgt_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int GRID_ROWS   = 4;
  localparam int GRID_COLS   = 4;
  localparam int DATA_WIDTH  = 32;

  localparam int NUM_STACKS = GRID_ROWS * GRID_COLS;
  localparam int SIDX_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int COORD_W  = 2;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 2;

  localparam int IN_BITS  = 4 * COORD_W + DATA_WIDTH;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + DATA_WIDTH + FILL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  localparam logic [FILL_W-1:0] FILL_EMPTY   = 2'd0;
  localparam logic [FILL_W-1:0] FILL_FULL    = 2'd1;
  localparam logic [FILL_W-1:0] FILL_PARTIAL = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 3'd0,
    KIND_PUSH  = 3'd1,
    KIND_POP   = 3'd2,
    KIND_READ  = 3'd3,
    KIND_MOVE  = 3'd4,
    KIND_COPY  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LD_SRC,
    CMD_LD_DST,
    CMD_EXEC,
    CMD_COPY,
    CMD_FINISH,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    logic xfer;
    logic copy_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [SIDX_W-1:0] stack_index(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
    int r;
    int c;
    r = int'(row) % GRID_ROWS;
    c = int'(col) % GRID_COLS;
    return SIDX_W'(r * GRID_COLS + c);
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SIDX_W-1:0] s,
                                                 input logic [CNT_W-1:0] i);
    return ADDR_W'(int'(s) * STACK_DEPTH + int'(i));
  endfunction

  function automatic logic [FILL_W-1:0] fill_code(input logic [CNT_W-1:0] cnt);
    logic [FILL_W-1:0] code;
    if (cnt == '0) begin
      code = FILL_EMPTY;
    end else if (cnt >= DEPTH_CNT) begin
      code = FILL_FULL;
    end else begin
      code = FILL_PARTIAL;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sgt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sgt_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire sgt_pkg::cmd_e                        cmd_i,
  input  wire logic [sgt_pkg::KIND_W-1:0]           kind_i,
  input  wire logic [sgt_pkg::COORD_W-1:0]          src_row_i,
  input  wire logic [sgt_pkg::COORD_W-1:0]          src_col_i,
  input  wire logic [sgt_pkg::COORD_W-1:0]          dst_row_i,
  input  wire logic [sgt_pkg::COORD_W-1:0]          dst_col_i,
  input  wire logic signed [sgt_pkg::DATA_WIDTH-1:0] value_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic [sgt_pkg::STATUS_W-1:0]              status_o,
  output logic signed [sgt_pkg::DATA_WIDTH-1:0]     top_value_o,
  output logic [sgt_pkg::FILL_W-1:0]                fill_state_o,
  output sgt_pkg::dp_status_t                       dp_status_o
);

  sgt_pkg::kind_e                       kind_q;
  logic [sgt_pkg::SIDX_W-1:0]           s_q;
  logic [sgt_pkg::SIDX_W-1:0]           d_q;
  logic signed [sgt_pkg::DATA_WIDTH-1:0] value_q;
  logic [sgt_pkg::CNT_W-1:0]            fs_q;
  logic [sgt_pkg::CNT_W-1:0]            rd_i_q;
  logic [sgt_pkg::CNT_W-1:0]            wr_cnt_q;
  logic                                 pend_q;
  logic                                 ovf_q;
  logic                                 top_ok_q;
  logic [sgt_pkg::CNT_W-1:0]            res_cnt_q;
  logic [sgt_pkg::STATUS_W-1:0]         res_status_q;
  logic [sgt_pkg::CNT_W-1:0]            fill_q [sgt_pkg::NUM_STACKS];

  logic signed [sgt_pkg::DATA_WIDTH-1:0] mem [sgt_pkg::MEM_DEPTH];
  logic signed [sgt_pkg::DATA_WIDTH-1:0] rdata_q;

  logic                                 out_valid_q;
  logic [sgt_pkg::STATUS_W-1:0]         out_status_q;
  logic signed [sgt_pkg::DATA_WIDTH-1:0] out_top_q;
  logic [sgt_pkg::FILL_W-1:0]           out_fill_q;

  logic                                 we;
  logic [sgt_pkg::ADDR_W-1:0]           waddr;
  logic signed [sgt_pkg::DATA_WIDTH-1:0] wdata;
  logic                                 re;
  logic [sgt_pkg::ADDR_W-1:0]           raddr;
  logic [sgt_pkg::SIDX_W-1:0]           fill_raddr;
  logic                                 src_empty;
  logic                                 src_full;
  logic                                 res_cmd;

  assign src_empty  = (fs_q == '0);
  assign src_full   = (fs_q >= sgt_pkg::DEPTH_CNT);
  assign fill_raddr = (cmd_i == sgt_pkg::CMD_LD_SRC) ? s_q : d_q;
  assign res_cmd    = (cmd_i == sgt_pkg::CMD_RESULT);

  always_comb begin
    we    = 1'b0;
    waddr = sgt_pkg::mem_addr(s_q, fs_q);
    wdata = value_q;
    re    = 1'b0;
    raddr = sgt_pkg::mem_addr(s_q, rd_i_q);
    case (cmd_i)
      sgt_pkg::CMD_EXEC: begin
        if (kind_q == sgt_pkg::KIND_PUSH && !src_full) begin
          we = 1'b1;
        end
        if (kind_q == sgt_pkg::KIND_READ && !src_empty) begin
          re    = 1'b1;
          raddr = sgt_pkg::mem_addr(s_q, fs_q - 1'b1);
        end
      end
      sgt_pkg::CMD_COPY: begin
        if (pend_q && wr_cnt_q < sgt_pkg::DEPTH_CNT) begin
          we    = 1'b1;
          waddr = sgt_pkg::mem_addr(d_q, wr_cnt_q);
          wdata = rdata_q;
        end
        if (rd_i_q < fs_q) begin
          re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == sgt_pkg::CMD_LATCH) begin
      kind_q  <= sgt_pkg::kind_e'(kind_i);
      s_q     <= sgt_pkg::stack_index(src_row_i, src_col_i);
      d_q     <= sgt_pkg::stack_index(dst_row_i, dst_col_i);
      value_q <= value_i;
    end
    if (res_cmd) begin
      out_status_q <= res_status_q;
      out_top_q    <= top_ok_q ? rdata_q : '0;
      out_fill_q   <= sgt_pkg::fill_code(res_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q         <= '0;
      rd_i_q       <= '0;
      wr_cnt_q     <= '0;
      pend_q       <= 1'b0;
      ovf_q        <= 1'b0;
      top_ok_q     <= 1'b0;
      res_cnt_q    <= '0;
      res_status_q <= sgt_pkg::ST_DONE;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < sgt_pkg::NUM_STACKS; k++) begin
        fill_q[k] <= '0;
      end
    end else begin
      if (res_cmd) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        sgt_pkg::CMD_LD_SRC: begin
          fs_q     <= fill_q[fill_raddr];
          rd_i_q   <= '0;
          top_ok_q <= 1'b0;
        end
        sgt_pkg::CMD_LD_DST: begin
          wr_cnt_q <= (kind_q == sgt_pkg::KIND_MOVE) ? '0 : fill_q[fill_raddr];
          rd_i_q   <= '0;
          pend_q   <= 1'b0;
          ovf_q    <= 1'b0;
        end
        sgt_pkg::CMD_EXEC: begin
          case (kind_q)
            sgt_pkg::KIND_CLEAR, sgt_pkg::KIND_MOVE: begin
              fill_q[s_q]  <= '0;
              res_cnt_q    <= '0;
              res_status_q <= sgt_pkg::ST_DONE;
            end
            sgt_pkg::KIND_PUSH: begin
              if (src_full) begin
                res_status_q <= sgt_pkg::ST_OVER;
                res_cnt_q    <= fs_q;
              end else begin
                fill_q[s_q]  <= fs_q + 1'b1;
                res_cnt_q    <= fs_q + 1'b1;
                res_status_q <= sgt_pkg::ST_DONE;
              end
            end
            sgt_pkg::KIND_POP: begin
              if (src_empty) begin
                res_status_q <= sgt_pkg::ST_UNDER;
                res_cnt_q    <= fs_q;
              end else begin
                fill_q[s_q]  <= fs_q - 1'b1;
                res_cnt_q    <= fs_q - 1'b1;
                res_status_q <= sgt_pkg::ST_DONE;
              end
            end
            sgt_pkg::KIND_READ: begin
              res_cnt_q <= fs_q;
              if (src_empty) begin
                res_status_q <= sgt_pkg::ST_UNDER;
              end else begin
                res_status_q <= sgt_pkg::ST_DONE;
                top_ok_q     <= 1'b1;
              end
            end
            default: begin
              res_cnt_q    <= fs_q;
              res_status_q <= sgt_pkg::ST_DONE;
            end
          endcase
        end
        sgt_pkg::CMD_COPY: begin
          if (pend_q) begin
            if (wr_cnt_q < sgt_pkg::DEPTH_CNT) begin
              wr_cnt_q <= wr_cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
          if (rd_i_q < fs_q) begin
            rd_i_q <= rd_i_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
        end
        sgt_pkg::CMD_FINISH: begin
          if (kind_q == sgt_pkg::KIND_MOVE) begin
            fill_q[s_q] <= '0;
          end
          fill_q[d_q]  <= wr_cnt_q;
          res_cnt_q    <= wr_cnt_q;
          res_status_q <= ovf_q ? sgt_pkg::ST_OVER : sgt_pkg::ST_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  assign dp_status_o.xfer      = (kind_q == sgt_pkg::KIND_COPY) ||
                                 (kind_q == sgt_pkg::KIND_MOVE && s_q != d_q);
  assign dp_status_o.copy_done = (rd_i_q >= fs_q) && !pend_q;
  assign dp_status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign top_value_o  = out_top_q;
  assign fill_state_o = out_fill_q;

  `SGT_ASSERT_NEVER(a_read_ptr_bound, rd_i_q > fs_q, "Copy read pointer passed the source fill.")
  `SGT_ASSERT_NEVER(a_write_ptr_bound, wr_cnt_q > sgt_pkg::DEPTH_CNT, "Write pointer overran.")
  `SGT_ASSERT(a_no_overwrite, res_cmd |-> !dp_status_o.out_busy, "Result overwrote a word.")
  `SGT_ASSERT_NEVER(a_pend_has_read, pend_q && rd_i_q == '0, "Pending word without a read.")

endmodule

`default_nettype wire

// File: hw/rtl/sgt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sgt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sgt_pkg::dp_status_t dp_status_i,
  output sgt_pkg::cmd_e            cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_SRC,
    S_LD_DST,
    S_EXEC,
    S_COPY,
    S_FINISH,
    S_RESULT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_LD_SRC;
          end
        end
        S_LD_SRC: begin
          state_q <= S_LD_DST;
        end
        S_LD_DST: begin
          state_q <= dp_status_i.xfer ? S_COPY : S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_RESULT;
        end
        S_COPY: begin
          if (dp_status_i.copy_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (!dp_status_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    case (state_q)
      S_IDLE:   cmd_o = in_valid_i ? sgt_pkg::CMD_LATCH : sgt_pkg::CMD_NONE;
      S_LD_SRC: cmd_o = sgt_pkg::CMD_LD_SRC;
      S_LD_DST: cmd_o = sgt_pkg::CMD_LD_DST;
      S_EXEC:   cmd_o = sgt_pkg::CMD_EXEC;
      S_COPY:   cmd_o = dp_status_i.copy_done ? sgt_pkg::CMD_NONE : sgt_pkg::CMD_COPY;
      S_FINISH: cmd_o = sgt_pkg::CMD_FINISH;
      S_RESULT: cmd_o = dp_status_i.out_busy ? sgt_pkg::CMD_NONE : sgt_pkg::CMD_RESULT;
      default:  cmd_o = sgt_pkg::CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/stack_grid_with_transfer.sv
`timescale 1ns / 1ps
`default_nettype none

// A 4 by 4 grid of stacks, each up to 8 words deep, driven by one operation per input word
// (clear, push, pop, read top, move, copy-append) and answering with exactly one result word.
// One item is in work at a time. Clear, push, pop and read top pass through load source, load
// destination and execute to the result register; move between two stacks and copy-append
// instead walk the source words through the item memory, which has one read and one write
// port, one word per cycle, and then pass a finish step. A finished result waits in the output
// register while the next word is taken.
// All stacks are empty after reset; no clearing pass is needed.
module stack_grid_with_transfer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: src_row, src_col, dst_row, dst_col, value.
  input  wire logic [sgt_pkg::IN_W-1:0]   s_axis_tdata,
  // tuser: kind.
  input  wire logic [sgt_pkg::KIND_W-1:0] s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // tdata: status, top_value, fill_state, zero fill.
  output logic [sgt_pkg::OUT_W-1:0]       m_axis_tdata
);

  localparam int CW = sgt_pkg::COORD_W;
  localparam int DW = sgt_pkg::DATA_WIDTH;

  sgt_pkg::cmd_e                  cmd;
  sgt_pkg::dp_status_t            dp_status;
  logic [sgt_pkg::STATUS_W-1:0]   status;
  logic signed [DW-1:0]           top_value;
  logic [sgt_pkg::FILL_W-1:0]     fill_state;

  sgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  sgt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (s_axis_tuser),
    .src_row_i    (s_axis_tdata[CW-1:0]),
    .src_col_i    (s_axis_tdata[2*CW-1:CW]),
    .dst_row_i    (s_axis_tdata[3*CW-1:2*CW]),
    .dst_col_i    (s_axis_tdata[4*CW-1:3*CW]),
    .value_i      (s_axis_tdata[4*CW+DW-1:4*CW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .status_o     (status),
    .top_value_o  (top_value),
    .fill_state_o (fill_state),
    .dp_status_o  (dp_status)
  );

  assign m_axis_tdata = {{(sgt_pkg::OUT_W - sgt_pkg::OUT_BITS){1'b0}}, fill_state,
                         top_value, status};

endmodule

`default_nettype wire

// File: sim/stack_grid_with_transfer_tb.sv
`timescale 1ns / 1ps

module stack_grid_with_transfer_tb;
  import sgt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int IDLE_PCT = 29;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [DATA_WIDTH-1:0] top_value;
    logic [FILL_W-1:0]     fill_state;
  } grid_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // tdata: src_row, src_col, dst_row, dst_col, value.
  logic [IN_W-1:0] s_axis_tdata = '0;
  // tuser: kind.
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // tdata: status, top_value, fill_state, zero fill.
  logic [OUT_W-1:0] m_axis_tdata;

  logic [DATA_WIDTH-1:0] grid_words [NUM_STACKS][STACK_DEPTH];
  int grid_fill [NUM_STACKS];
  grid_result_t pending_results [$];

  int mismatch_cnt = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;

  stack_grid_with_transfer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic grid_result_t predict_grid_op(input logic [KIND_W-1:0] kind,
                                                   input logic [COORD_W-1:0] sr,
                                                   input logic [COORD_W-1:0] sc,
                                                   input logic [COORD_W-1:0] dr,
                                                   input logic [COORD_W-1:0] dc,
                                                   input logic [DATA_WIDTH-1:0] word);
    grid_result_t res;
    logic [DATA_WIDTH-1:0] snap [STACK_DEPTH];
    int s;
    int d;
    int shown;
    int n;
    s = (int'(sr) % GRID_ROWS) * GRID_COLS + int'(sc) % GRID_COLS;
    d = (int'(dr) % GRID_ROWS) * GRID_COLS + int'(dc) % GRID_COLS;
    shown = s;
    res.status = ST_DONE;
    res.top_value = '0;
    case (kind)
      KIND_CLEAR: begin
        grid_fill[s] = 0;
      end
      KIND_PUSH: begin
        if (grid_fill[s] >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          grid_words[s][grid_fill[s]] = word;
          grid_fill[s]++;
        end
      end
      KIND_POP: begin
        if (grid_fill[s] == 0) res.status = ST_UNDER;
        else grid_fill[s]--;
      end
      KIND_READ: begin
        if (grid_fill[s] == 0) res.status = ST_UNDER;
        else res.top_value = grid_words[s][grid_fill[s] - 1];
      end
      KIND_MOVE: begin
        shown = d;
        if (s == d) begin
          grid_fill[s] = 0;
        end else begin
          n = grid_fill[s];
          for (int i = 0; i < n; i++) grid_words[d][i] = grid_words[s][i];
          grid_fill[d] = n;
          grid_fill[s] = 0;
        end
      end
      KIND_COPY: begin
        shown = d;
        n = grid_fill[s];
        for (int i = 0; i < n; i++) snap[i] = grid_words[s][i];
        for (int i = 0; i < n; i++) begin
          if (grid_fill[d] >= STACK_DEPTH) begin
            res.status = ST_OVER;
            break;
          end
          grid_words[d][grid_fill[d]] = snap[i];
          grid_fill[d]++;
        end
      end
      default: begin
      end
    endcase
    if (grid_fill[shown] == 0) res.fill_state = FILL_EMPTY;
    else if (grid_fill[shown] >= STACK_DEPTH) res.fill_state = FILL_FULL;
    else res.fill_state = FILL_PARTIAL;
    return res;
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic [COORD_W-1:0] sr,
                         input logic [COORD_W-1:0] sc,
                         input logic [COORD_W-1:0] dr,
                         input logic [COORD_W-1:0] dc,
                         input logic [DATA_WIDTH-1:0] word);
    while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= IN_W'({word, dc, dr, sc, sr});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_grid_op(kind, sr, sc, dr, dc, word));
  endtask

  task automatic send_random_op();
    logic [KIND_W-1:0] kind;
    logic [COORD_W-1:0] sr;
    logic [COORD_W-1:0] sc;
    logic [COORD_W-1:0] dr;
    logic [COORD_W-1:0] dc;
    logic [DATA_WIDTH-1:0] word;
    int pick;
    pick = $urandom_range(99);
    if (pick < 36) kind = KIND_PUSH;
    else if (pick < 48) kind = KIND_POP;
    else if (pick < 60) kind = KIND_READ;
    else if (pick < 65) kind = KIND_CLEAR;
    else if (pick < 77) kind = KIND_MOVE;
    else if (pick < 94) kind = KIND_COPY;
    else if (pick < 97) kind = KIND_SPARE6;
    else kind = KIND_SPARE7;
    // Most traffic goes to a few stacks so that they fill up and overflow.
    if ($urandom_range(99) < 70) begin
      sr = COORD_W'($urandom_range(1));
      sc = COORD_W'($urandom_range(1));
      dr = COORD_W'($urandom_range(1));
      dc = COORD_W'($urandom_range(1));
    end else begin
      sr = COORD_W'($urandom);
      sc = COORD_W'($urandom);
      dr = COORD_W'($urandom);
      dc = COORD_W'($urandom);
    end
    case ($urandom_range(9))
      0: word = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: word = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: word = '0;
      3: word = '1;
      default: word = DATA_WIDTH'($urandom);
    endcase
    send_op(kind, sr, sc, dr, dc, word);
  endtask

  task automatic test_empty_stacks();
    send_op(KIND_READ, 2'd3, 2'd3, 2'd0, 2'd0, '1);
    send_op(KIND_POP, 2'd0, 2'd0, 2'd3, 2'd3, '0);
    send_op(KIND_SPARE6, 2'd1, 2'd2, 2'd3, 2'd0, 32'h1234_5678);
    send_op(KIND_SPARE7, 2'd2, 2'd1, 2'd0, 2'd3, 32'h8765_4321);
  endtask

  task automatic test_push_overflow();
    send_op(KIND_PUSH, 2'd0, 2'd0, 2'd3, 2'd3, 32'h8000_0000);
    send_op(KIND_PUSH, 2'd0, 2'd0, 2'd3, 2'd3, 32'h7fff_ffff);
    send_op(KIND_PUSH, 2'd0, 2'd0, 2'd3, 2'd3, 32'h0000_0000);
    send_op(KIND_PUSH, 2'd0, 2'd0, 2'd3, 2'd3, 32'hffff_ffff);
    for (int i = 0; i < 4; i++) begin
      send_op(KIND_PUSH, 2'd0, 2'd0, 2'd3, 2'd3, DATA_WIDTH'($urandom));
    end
    send_op(KIND_PUSH, 2'd0, 2'd0, 2'd3, 2'd3, 32'h5555_aaaa);
    send_op(KIND_READ, 2'd0, 2'd0, 2'd3, 2'd3, '0);
    send_op(KIND_SPARE6, 2'd0, 2'd0, 2'd1, 2'd1, '0);
  endtask

  task automatic test_transfers();
    send_op(KIND_COPY, 2'd0, 2'd0, 2'd0, 2'd0, '0);
    send_op(KIND_MOVE, 2'd0, 2'd0, 2'd1, 2'd1, '0);
    for (int i = 0; i < 5; i++) send_op(KIND_POP, 2'd1, 2'd1, 2'd0, 2'd0, '0);
    send_op(KIND_COPY, 2'd1, 2'd1, 2'd1, 2'd1, '0);
    send_op(KIND_COPY, 2'd1, 2'd1, 2'd1, 2'd1, '0);
    send_op(KIND_READ, 2'd1, 2'd1, 2'd0, 2'd0, '0);
    send_op(KIND_MOVE, 2'd2, 2'd2, 2'd1, 2'd1, '0);
    send_op(KIND_PUSH, 2'd3, 2'd0, 2'd0, 2'd0, 32'hdead_beef);
    send_op(KIND_MOVE, 2'd3, 2'd0, 2'd3, 2'd0, '0);
    send_op(KIND_PUSH, 2'd2, 2'd1, 2'd0, 2'd0, 32'h0bad_f00d);
    send_op(KIND_CLEAR, 2'd2, 2'd1, 2'd0, 2'd0, '0);
  endtask

  task automatic test_random_ops();
    repeat (1400) send_random_op();
  endtask

  task automatic test_output_backpressure();
    hold_req = ~hold_req;
    repeat (150) send_random_op();
  endtask

  task automatic test_back_to_back();
    burst_mode = 1'b1;
    repeat (300) send_random_op();
    burst_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("Unexpected result word %h", m_axis_tdata);
        end
      end else begin
        grid_result_t exp_res;
        grid_result_t got_res;
        exp_res = pending_results.pop_front();
        got_res.status = m_axis_tdata[STATUS_W-1:0];
        got_res.top_value = m_axis_tdata[STATUS_W +: DATA_WIDTH];
        got_res.fill_state = m_axis_tdata[STATUS_W + DATA_WIDTH +: FILL_W];
        if (got_res.status !== exp_res.status || got_res.top_value !== exp_res.top_value ||
            got_res.fill_state !== exp_res.fill_state) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("Mismatch: expected status %0d top %h fill %0d, got status %0d top %h fill %0d",
                     exp_res.status, exp_res.top_value, exp_res.fill_state,
                     got_res.status, got_res.top_value, got_res.fill_state);
          end
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (burst_mode) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NUM_STACKS; s++) grid_fill[s] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_stacks();
    test_push_overflow();
    test_transfers();
    test_random_ops();
    test_output_backpressure();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
